FILE: rtl/tam_pkg.sv
package tam_pkg;

  localparam int DEF_SAMPLE_DEPTH  = 64;
  localparam int DEF_READ_PERIOD   = 30;
  localparam int DEF_BUTTON_PERIOD = 20;
  localparam int DEF_ADC_BITS      = 12;

  localparam int SAMPLE_W = 12;
  localparam int BETA_W   = 14;
  localparam int TEMP_W   = 16;
  localparam int SET_W    = 12;

  // log2 result: 5 integer bits, 16 fraction bits
  localparam int EXP_W  = 5;
  localparam int FRAC_W = 16;
  localparam int LOG_W  = EXP_W + FRAC_W;
  localparam int MANT_W = 32;
  localparam int DIV_W  = 48;

  localparam logic [EXP_W-1:0]  EXP_START = EXP_W'(30);
  localparam logic [3:0]        LOG_LAST  = 4'hF;
  localparam logic [23:0]       LN2_Q24   = 24'd11629080;
  localparam logic [DIV_W-1:0]  INV_TN_Q40 =
      DIV_W'(((longint'(1) << 40) * 100 + 29815 / 2) / 29815);
  localparam logic [DIV_W-1:0]  KC_NUMER  = DIV_W'(longint'(100) << 40);

  localparam logic signed [TEMP_W-1:0] TEMP_LOW  = -16'sd27315;
  localparam logic signed [TEMP_W-1:0] TEMP_HIGH = 16'sd20000;
  localparam logic [DIV_W-1:0]         KC_LIMIT  = DIV_W'(47315);
  localparam logic [DIV_W-1:0]         KC_OFFSET = DIV_W'(27315);
  localparam logic signed [SET_W:0]    SET_LOW   = -13'sd400;
  localparam logic signed [SET_W:0]    SET_HIGH  = 13'sd1500;
  localparam logic signed [SET_W-1:0]  SET_RESET = 12'sd600;
  localparam logic [BETA_W-1:0]        BETA_RESET = 14'd3950;

  localparam logic DIV_SEL_LN = 1'b0;
  localparam logic DIV_SEL_KC = 1'b1;

  typedef struct packed {
    logic       capture;
    logic       accum;
    logic       temp_low;
    logic       log_load;
    logic       log_sel;
    logic       log_norm;
    logic       log_mul;
    logic       log_sq;
    logic [3:0] log_bit;
    logic       log_save;
    logic       ln_mul;
    logic       div_start;
    logic       div_sel;
    logic       den_calc;
    logic       temp_final;
    logic       btn_step;
    logic       out_load;
  } tam_cmd_t;

  typedef struct packed {
    logic read_tick;
    logic button_tick;
    logic total_zero;
    logic norm_done;
    logic div_done;
    logic den_pos;
    logic out_free;
  } tam_sts_t;

endpackage

FILE: rtl/tam_ram.sv
module tam_ram import tam_pkg::*; #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/tam_div.sv
module tam_div import tam_pkg::*; #(
  parameter int W = DIV_W
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic [W-1:0] quotient,
  output logic         done
);

  localparam int CW = $clog2(W);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [W-1:0]  rem;
  logic [W-1:0]  dsor;
  logic [W:0]    shifted;
  logic          ge;

  // One quotient bit per cycle, restoring form.
  assign shifted = {rem, quotient[W-1]};
  assign ge      = shifted >= {1'b0, dsor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
      dsor     <= divisor;
    end else if (busy) begin
      rem      <= ge ? W'(shifted - {1'b0, dsor}) : shifted[W-1:0];
      quotient <= {quotient[W-2:0], ge};
    end
  end

endmodule

FILE: rtl/tam_datapath.sv
module tam_datapath import tam_pkg::*; #(
  parameter int SAMPLE_DEPTH  = DEF_SAMPLE_DEPTH,
  parameter int READ_PERIOD   = DEF_READ_PERIOD,
  parameter int BUTTON_PERIOD = DEF_BUTTON_PERIOD,
  parameter int ADC_BITS      = DEF_ADC_BITS
) (
  input  logic                     clk,
  input  logic                     rst,
  input  tam_cmd_t                 cmd,
  output tam_sts_t                 sts,
  input  logic [SAMPLE_W-1:0]      adc_sample,
  input  logic                     raise_pressed,
  input  logic                     lower_pressed,
  input  logic                     cfg_we,
  input  logic [BETA_W-1:0]        cfg_wdata,
  input  logic                     out_ready,
  output logic                     out_valid,
  output logic signed [TEMP_W-1:0] temperature_centi,
  output logic signed [SET_W-1:0]  setpoint_deci,
  output logic                     alarm,
  output logic                     temperature_updated
);

  localparam int PW   = $clog2(SAMPLE_DEPTH);
  localparam longint FULL_SCALE = (longint'(1) << ADC_BITS) * SAMPLE_DEPTH;
  localparam int SUM_W = $clog2(FULL_SCALE + 1);
  localparam int RC_W = $clog2(READ_PERIOD + 1);
  localparam int BC_W = $clog2(BUTTON_PERIOD + 1);
  localparam logic [SAMPLE_W-1:0] ADC_MASK =
      (ADC_BITS >= SAMPLE_W) ? {SAMPLE_W{1'b1}} : SAMPLE_W'((1 << ADC_BITS) - 1);

  // tick bookkeeping
  logic [RC_W-1:0]     read_cnt;
  logic [BC_W-1:0]     button_cnt;
  logic                read_tick;
  logic                button_tick;
  logic [ADC_BITS-1:0] sample;
  logic                raise_q;
  logic                lower_q;

  // ring
  logic [PW-1:0]       pos;
  logic                ring_full;
  logic [ADC_BITS-1:0] ram_rdata;
  logic [ADC_BITS-1:0] old_sample;
  logic [SUM_W-1:0]    total;

  // conversion
  logic [BETA_W-1:0]        beta;
  logic [MANT_W-1:0]        mant;
  logic [EXP_W-1:0]         expo;
  logic [FRAC_W-1:0]        frac;
  logic [2*MANT_W-3:0]      sq_prod;
  logic [MANT_W-1:0]        sq;
  logic [LOG_W-1:0]         log_a;
  logic signed [LOG_W:0]    lg;
  logic signed [46:0]       ln_prod;
  logic signed [DIV_W-1:0]  lnq;
  logic signed [DIV_W-1:0]  den;
  logic [DIV_W-1:0]         div_dividend;
  logic [DIV_W-1:0]         div_divisor;
  logic [DIV_W-1:0]         quo;
  logic                     div_done;
  logic [DIV_W-1:0]         beta_eff;
  logic [DIV_W-1:0]         q_signed;
  logic signed [TEMP_W-1:0] held_temp;
  logic signed [TEMP_W-1:0] temp_result;
  logic signed [TEMP_W-1:0] thr_scaled;
  logic signed [SET_W-1:0]  threshold;
  logic signed [SET_W:0]    set_sum;
  logic                     alarm_level;

  tam_ram #(.WIDTH(ADC_BITS), .DEPTH(SAMPLE_DEPTH)) u_ring (
    .clk   (clk),
    .we    (cmd.accum),
    .waddr (pos),
    .wdata (sample),
    .re    (cmd.capture),
    .raddr (pos),
    .rdata (ram_rdata)
  );

  tam_div #(.W(DIV_W)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (quo),
    .done     (div_done)
  );

  // Entries are written in ring order, so nothing past pos was written before the first wrap.
  assign old_sample = ring_full ? ram_rdata : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      read_cnt    <= '0;
      button_cnt  <= '0;
      read_tick   <= 1'b0;
      button_tick <= 1'b0;
      pos         <= '0;
      ring_full   <= 1'b0;
      total       <= '0;
      beta        <= BETA_RESET;
      threshold   <= SET_RESET;
      held_temp   <= '0;
      alarm_level <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        beta <= cfg_wdata;
      end
      if (cmd.capture) begin
        read_tick   <= (read_cnt == RC_W'(READ_PERIOD - 1));
        button_tick <= (button_cnt == BC_W'(BUTTON_PERIOD - 1));
        read_cnt    <= (read_cnt == RC_W'(READ_PERIOD - 1)) ? '0 : read_cnt + 1'b1;
        button_cnt  <= (button_cnt == BC_W'(BUTTON_PERIOD - 1)) ? '0 : button_cnt + 1'b1;
      end
      if (cmd.accum) begin
        total <= total - SUM_W'(old_sample) + SUM_W'(sample);
        if (pos == PW'(SAMPLE_DEPTH - 1)) begin
          pos       <= '0;
          ring_full <= 1'b1;
        end else begin
          pos <= pos + 1'b1;
        end
      end
      if (cmd.temp_low || cmd.temp_final) begin
        held_temp   <= temp_result;
        alarm_level <= temp_result > thr_scaled;
      end
      if (cmd.btn_step) begin
        if (set_sum < SET_LOW) begin
          threshold <= SET_LOW[SET_W-1:0];
        end else if (set_sum > SET_HIGH) begin
          threshold <= SET_HIGH[SET_W-1:0];
        end else begin
          threshold <= set_sum[SET_W-1:0];
        end
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign set_sum    = {threshold[SET_W-1], threshold} + (SET_W+1)'(raise_q)
                      - (SET_W+1)'(lower_q);
  assign thr_scaled = (TEMP_W'(threshold) <<< 3) + (TEMP_W'(threshold) <<< 1);

  always_comb begin
    if (cmd.temp_low) begin
      temp_result = TEMP_LOW;
    end else if (quo > KC_LIMIT) begin
      temp_result = TEMP_HIGH;
    end else begin
      temp_result = TEMP_W'(quo - KC_OFFSET);
    end
  end

  // Log2 by repeated squaring of a Q30 mantissa.
  assign sq = sq_prod[2*MANT_W-3:MANT_W-2];
  assign lg = $signed({1'b0, log_a}) - $signed({1'b0, expo, frac});
  assign beta_eff = (beta == '0) ? DIV_W'(1) : DIV_W'(beta);
  assign q_signed = lnq[DIV_W-1] ? DIV_W'(-quo) : quo;

  always_comb begin
    if (cmd.div_sel == DIV_SEL_KC) begin
      div_dividend = KC_NUMER + DIV_W'(den >>> 1);
      div_divisor  = den;
    end else begin
      div_dividend = lnq[DIV_W-1] ? DIV_W'(-lnq) : lnq;
      div_divisor  = beta_eff;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      sample  <= ADC_BITS'(adc_sample & ADC_MASK);
      raise_q <= raise_pressed;
      lower_q <= lower_pressed;
    end
    if (cmd.log_load) begin
      mant <= cmd.log_sel ? MANT_W'(SUM_W'(FULL_SCALE) - total) : MANT_W'(total);
      expo <= EXP_START;
      frac <= '0;
    end else if (cmd.log_norm) begin
      mant <= mant << 1;
      expo <= expo - 1'b1;
    end else if (cmd.log_sq) begin
      if (sq[MANT_W-1]) begin
        mant               <= sq >> 1;
        frac[cmd.log_bit]  <= 1'b1;
      end else begin
        mant <= sq;
      end
    end
    if (cmd.log_mul) begin
      sq_prod <= mant[MANT_W-2:0] * mant[MANT_W-2:0];
    end
    if (cmd.log_save) begin
      log_a <= {expo, frac};
    end
    if (cmd.ln_mul) begin
      lnq <= DIV_W'(ln_prod);
    end
    if (cmd.den_calc) begin
      den <= $signed(INV_TN_Q40 + q_signed);
    end
    if (cmd.out_load) begin
      temperature_centi   <= held_temp;
      setpoint_deci       <= threshold;
      alarm               <= alarm_level;
      temperature_updated <= read_tick;
    end
  end

  assign ln_prod = lg * $signed({1'b0, LN2_Q24});

  assign sts.read_tick   = read_tick;
  assign sts.button_tick = button_tick;
  assign sts.total_zero  = (total == '0);
  assign sts.norm_done   = mant[MANT_W-2];
  assign sts.div_done    = div_done;
  assign sts.den_pos     = !den[DIV_W-1] && (den != '0);
  assign sts.out_free    = !out_valid || out_ready;

endmodule

FILE: rtl/tam_ctrl.sv
module tam_ctrl import tam_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  tam_sts_t sts,
  output tam_cmd_t cmd
);

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_ACCUM  = 5'd1;
  localparam logic [4:0] S_CHECK  = 5'd2;
  localparam logic [4:0] S_LOAD   = 5'd3;
  localparam logic [4:0] S_NORM   = 5'd4;
  localparam logic [4:0] S_MUL    = 5'd5;
  localparam logic [4:0] S_SQ     = 5'd6;
  localparam logic [4:0] S_SAVE   = 5'd7;
  localparam logic [4:0] S_LNMUL  = 5'd8;
  localparam logic [4:0] S_DIV1   = 5'd9;
  localparam logic [4:0] S_WAIT1  = 5'd10;
  localparam logic [4:0] S_DEN    = 5'd11;
  localparam logic [4:0] S_DENCHK = 5'd12;
  localparam logic [4:0] S_WAIT2  = 5'd13;
  localparam logic [4:0] S_FINAL  = 5'd14;
  localparam logic [4:0] S_BTN    = 5'd15;
  localparam logic [4:0] S_OUT    = 5'd16;

  logic [4:0] state;
  logic [4:0] state_next;
  logic [3:0] step;
  logic [3:0] step_next;
  logic       second;
  logic       second_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      step   <= '0;
      second <= 1'b0;
    end else begin
      state  <= state_next;
      step   <= step_next;
      second <= second_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd         = '0;
    state_next  = state;
    step_next   = step;
    second_next = second;
    cmd.log_sel = second;
    cmd.log_bit = ~step;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_ACCUM;
        end
      end
      S_ACCUM: begin
        cmd.accum  = 1'b1;
        state_next = S_CHECK;
      end
      S_CHECK: begin
        if (!sts.read_tick) begin
          state_next = S_BTN;
        end else if (sts.total_zero) begin
          cmd.temp_low = 1'b1;
          state_next   = S_BTN;
        end else begin
          second_next = 1'b0;
          state_next  = S_LOAD;
        end
      end
      S_LOAD: begin
        cmd.log_load = 1'b1;
        state_next   = S_NORM;
      end
      S_NORM: begin
        if (sts.norm_done) begin
          step_next  = '0;
          state_next = S_MUL;
        end else begin
          cmd.log_norm = 1'b1;
        end
      end
      S_MUL: begin
        cmd.log_mul = 1'b1;
        state_next  = S_SQ;
      end
      S_SQ: begin
        cmd.log_sq = 1'b1;
        if (step == LOG_LAST) begin
          state_next = second ? S_LNMUL : S_SAVE;
        end else begin
          step_next  = step + 1'b1;
          state_next = S_MUL;
        end
      end
      S_SAVE: begin
        cmd.log_save = 1'b1;
        second_next  = 1'b1;
        state_next   = S_LOAD;
      end
      S_LNMUL: begin
        cmd.ln_mul = 1'b1;
        state_next = S_DIV1;
      end
      S_DIV1: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_SEL_LN;
        state_next    = S_WAIT1;
      end
      S_WAIT1: begin
        if (sts.div_done) begin
          state_next = S_DEN;
        end
      end
      S_DEN: begin
        cmd.den_calc = 1'b1;
        state_next   = S_DENCHK;
      end
      S_DENCHK: begin
        if (sts.den_pos) begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = DIV_SEL_KC;
          state_next    = S_WAIT2;
        end else begin
          cmd.temp_low = 1'b1;
          state_next   = S_BTN;
        end
      end
      S_WAIT2: begin
        cmd.div_sel = DIV_SEL_KC;
        if (sts.div_done) begin
          state_next = S_FINAL;
        end
      end
      S_FINAL: begin
        cmd.temp_final = 1'b1;
        state_next     = S_BTN;
      end
      S_BTN: begin
        cmd.btn_step = sts.button_tick;
        state_next   = S_OUT;
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/thermistor_alarm_monitor_unit.sv
// A tick without a temperature update runs the accumulate, check, button and output states.
// A conversion tick adds two log2 passes (normalize plus 16 squaring steps, each a multiply
// and a square state) and two 48-step passes of the shared divider.
// Throughput: one transaction at a time; the next input is taken once the result is queued.
// Reset (rst, synchronous, active high) clears the average, setpoint to 60.0 C and beta to
// 3950; the sample ring needs no clearing pass since unwritten entries read as zero.
module thermistor_alarm_monitor_unit import tam_pkg::*; #(
  parameter int SAMPLE_DEPTH  = DEF_SAMPLE_DEPTH,
  parameter int READ_PERIOD   = DEF_READ_PERIOD,
  parameter int BUTTON_PERIOD = DEF_BUTTON_PERIOD,
  parameter int ADC_BITS      = DEF_ADC_BITS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,    // adc_sample[11:0], raise_pressed[12], lower_pressed[13]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,    // temperature_centi[15:0], setpoint_deci[27:16], alarm[28]
  output logic [0:0]  m_tuser,    // temperature_updated[0]
  input  logic        cfg_we,
  input  logic [13:0] cfg_wdata
);

  tam_cmd_t                 cmd;
  tam_sts_t                 sts;
  logic signed [TEMP_W-1:0] temperature_centi;
  logic signed [SET_W-1:0]  setpoint_deci;
  logic                     alarm;
  logic                     temperature_updated;

  tam_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  tam_datapath #(
    .SAMPLE_DEPTH  (SAMPLE_DEPTH),
    .READ_PERIOD   (READ_PERIOD),
    .BUTTON_PERIOD (BUTTON_PERIOD),
    .ADC_BITS      (ADC_BITS)
  ) u_dp (
    .clk                 (clk),
    .rst                 (rst),
    .cmd                 (cmd),
    .sts                 (sts),
    .adc_sample          (s_tdata[11:0]),
    .raise_pressed       (s_tdata[12]),
    .lower_pressed       (s_tdata[13]),
    .cfg_we              (cfg_we),
    .cfg_wdata           (cfg_wdata),
    .out_ready           (m_tready),
    .out_valid           (m_tvalid),
    .temperature_centi   (temperature_centi),
    .setpoint_deci       (setpoint_deci),
    .alarm               (alarm),
    .temperature_updated (temperature_updated)
  );

  assign m_tdata = {3'b000, alarm, setpoint_deci, temperature_centi};
  assign m_tuser = temperature_updated;

  // Only one transaction is in the datapath at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input accepted while a transaction is in progress");

  a_setpoint_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ($signed(setpoint_deci) >= -12'sd400 && $signed(setpoint_deci) <= 12'sd1500))
    else $error("setpoint outside its clamp range");

  a_temp_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (temperature_centi >= TEMP_LOW && temperature_centi <= TEMP_HIGH))
    else $error("temperature outside its clamp range");

endmodule

FILE: tb/thermistor_alarm_monitor_unit_test.sv
`timescale 1ns / 1ps

module thermistor_alarm_monitor_unit_test;

  localparam int    PHASE_SPAN = 60;
  localparam int    FULL_TOTAL = 4096 * 64;
  localparam longint Q40_ONE   = longint'(1) << 40;
  localparam longint INV_TN    = (Q40_ONE * 100 + 29815 / 2) / 29815;
  localparam longint LN2_FIX   = 11629080;
  localparam int    SETTLE     = 300;
  localparam int    STALL_LIMIT = 20000;

  typedef struct packed {
    logic signed [15:0] temp;
    logic signed [11:0] setp;
    logic               alarm;
    logic               updated;
  } reading_t;

  typedef struct {
    logic [11:0] adc;
    bit          raise;
    bit          lower;
    bit          typed;
    reading_t    want;
  } tick_row_t;

  logic        clk = 0;
  logic        rst = 1;
  logic        s_tvalid = 0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 0;
  logic [31:0] m_tdata;
  logic [0:0]  m_tuser;
  logic        cfg_we = 0;
  logic [13:0] cfg_wdata = '0;

  thermistor_alarm_monitor_unit DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // Predictor state
  logic [11:0] ring_mem [64];
  int          ring_ptr;
  int          avg_total;
  int          phase_cnt;
  int          held_temp;
  int          thresh;
  bit          alarm_q;
  int          beta_reg;

  reading_t    pending_readings[$];
  int          n_accepted;
  int          errors;
  bit          typed_on;
  reading_t    typed_reading;
  bit          gaps_on;
  bit          rx_stall_on;
  int          burst_left;
  int          idle_cycles;
  logic [7:0]  rx_cnt;

  function automatic longint log2_fix(longint unsigned x);
    int e;
    longint unsigned m;
    longint r;
    e = 0;
    while ((x >> (e + 1)) != 0 && e < 62) e++;
    m = (e <= 30) ? (x << (30 - e)) : (x >> (e - 30));
    r = longint'(e) << 16;
    for (int i = 0; i < 16; i++) begin
      m = (m * m) >> 30;
      if (m >= (longint'(2) << 30)) begin
        m = m >> 1;
        r = r | (longint'(1) << (15 - i));
      end
    end
    return r;
  endfunction

  function automatic int beta_temperature(int total, int beta_raw);
    longint beta, lg, den, kc;
    beta = (beta_raw == 0) ? 1 : beta_raw;
    if (total == 0 || total >= FULL_TOTAL) return -27315;
    lg = log2_fix(total) - log2_fix(FULL_TOTAL - total);
    den = INV_TN + (lg * LN2_FIX) / beta;
    if (den <= 0) return -27315;
    kc = (Q40_ONE * 100 + den / 2) / den;
    if (kc > 47315) return 20000;
    if (kc - 27315 < -27315) return -27315;
    return int'(kc - 27315);
  endfunction

  function automatic reading_t advance_tick(logic [15:0] item);
    reading_t r;
    int s;
    bit upd;
    upd = 0;
    phase_cnt = (phase_cnt + 1) % PHASE_SPAN;
    avg_total = avg_total - ring_mem[ring_ptr] + item[11:0];
    ring_mem[ring_ptr] = item[11:0];
    ring_ptr = (ring_ptr + 1) % 64;
    if (phase_cnt % 30 == 0) begin
      held_temp = beta_temperature(avg_total, beta_reg);
      alarm_q = held_temp > thresh * 10;
      upd = 1;
    end
    if (phase_cnt % 20 == 0) begin
      s = thresh + item[12] - item[13];
      if (s < -400) s = -400;
      if (s > 1500) s = 1500;
      thresh = s;
    end
    r.temp = 16'(held_temp);
    r.setp = 12'(thresh);
    r.alarm = alarm_q;
    r.updated = upd;
    return r;
  endfunction

  always @(posedge clk) begin
    reading_t w;
    if (rst) begin
      for (int i = 0; i < 64; i++) ring_mem[i] = '0;
      ring_ptr = 0; avg_total = 0; phase_cnt = 0; held_temp = 0;
      thresh = 600; alarm_q = 0; beta_reg = 3950;
    end else begin
      if (m_tvalid && m_tready) begin
        if (pending_readings.size() == 0) begin
          $error("result transaction with nothing expected");
          errors++;
        end else begin
          w = pending_readings.pop_front();
          if ($signed(m_tdata[15:0]) !== w.temp) begin
            $error("temperature_centi: expected %0d, actual %0d", w.temp, $signed(m_tdata[15:0]));
            errors++;
          end
          if ($signed(m_tdata[27:16]) !== w.setp) begin
            $error("setpoint_deci: expected %0d, actual %0d", w.setp, $signed(m_tdata[27:16]));
            errors++;
          end
          if (m_tdata[28] !== w.alarm) begin
            $error("alarm: expected %0b, actual %0b", w.alarm, m_tdata[28]);
            errors++;
          end
          if (m_tuser[0] !== w.updated) begin
            $error("temperature_updated: expected %0b, actual %0b", w.updated, m_tuser[0]);
            errors++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        w = advance_tick(s_tdata);
        pending_readings.push_back(typed_on ? typed_reading : w);
        n_accepted <= n_accepted + 1;
      end
      if (cfg_we) beta_reg = cfg_wdata;
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("thermistor_alarm_monitor_unit_test: FAIL");
        $finish;
      end
    end
  end

  // Receiver: mostly ready, with a repeating stall window of random backpressure.
  always @(negedge clk) begin
    rx_cnt <= rx_cnt + 8'd1;
    if (!rx_stall_on) m_tready <= 1;
    else if (rx_cnt[5:0] < 6'd24) m_tready <= 1;
    else m_tready <= ($urandom_range(0, 2) == 0);
  end

  task automatic send_tick(logic [11:0] adc, bit raise, bit lower);
    int target;
    if (gaps_on && burst_left <= 0) begin
      s_tvalid <= 0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
      burst_left = $urandom_range(1, 12);
    end
    target = n_accepted + 1;
    s_tvalid <= 1;
    s_tdata <= {2'b00, lower, raise, adc};
    @(negedge clk);
    while (n_accepted != target) @(negedge clk);
    burst_left--;
  endtask

  task automatic drain_results();
    s_tvalid <= 0;
    while (pending_readings.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_beta(int value);
    cfg_we <= 1;
    cfg_wdata <= 14'(value);
    @(negedge clk);
    cfg_we <= 0;
    @(negedge clk);
  endtask

  // Runs of one sample shape, 20 to 110 samples long, so that the longer ones fill the ring and
  // empty and full-scale averages, both clamps and the cold range all get reached.
  task automatic random_ticks(int count);
    int sent, run_len, shape, base;
    logic [11:0] adc;
    sent = 0;
    while (sent < count) begin
      shape = $urandom_range(0, 5);
      run_len = $urandom_range(20, 110);
      base = $urandom_range(0, 4095);
      for (int i = 0; i < run_len && sent < count; i++) begin
        case (shape)
          0: adc = 12'd0;
          1: adc = 12'hFFF;
          2: adc = 12'($urandom_range(0, 4095));
          3: adc = 12'((base + $urandom_range(0, 40) > 4095) ? 4095 : base + $urandom_range(0, 40));
          4: adc = 12'($urandom_range(0, 60));
          default: adc = 12'($urandom_range(4000, 4095));
        endcase
        send_tick(adc, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        sent++;
      end
    end
  endtask

  tick_row_t directed_rows[$];

  function automatic tick_row_t row(logic [11:0] adc, bit raise, bit lower, bit typed = 0,
                                    int temp = 0, int setp = 0);
    tick_row_t t;
    t.adc = adc; t.raise = raise; t.lower = lower; t.typed = typed;
    t.want.temp = 16'(temp); t.want.setp = 12'(setp);
    t.want.alarm = 0; t.want.updated = 0;
    return t;
  endfunction

  initial begin
    n_accepted = 0; errors = 0; typed_on = 0; gaps_on = 1; rx_stall_on = 1;
    burst_left = 0; idle_cycles = 0; rx_cnt = 0;

    // Right after reset: nothing computed, setpoint at its reset value.
    directed_rows.push_back(row(12'd0, 0, 0, 1, 0, 600));
    directed_rows.push_back(row(12'hFFF, 1, 1, 1, 0, 600));
    directed_rows.push_back(row(12'hFFF, 0, 0));
    directed_rows.push_back(row(12'h000, 1, 0));
    directed_rows.push_back(row(12'hAAA, 0, 1));
    directed_rows.push_back(row(12'h555, 1, 1));
    for (int i = 0; i < 13; i++) directed_rows.push_back(row(12'(12'h800 + i), i[0], i[1]));
    // Tick 20 is a button tick: both buttons held cancel out.
    directed_rows.push_back(row(12'h001, 1, 1, 1, 0, 600));
    directed_rows.push_back(row(12'hFFE, 1, 0));
    directed_rows.push_back(row(12'h7FF, 0, 1));
    directed_rows.push_back(row(12'hFFF, 1, 1));

    repeat (12) @(negedge clk);
    rst <= 0;
    @(negedge clk);

    foreach (directed_rows[i]) begin
      typed_on = directed_rows[i].typed;
      typed_reading = directed_rows[i].want;
      send_tick(directed_rows[i].adc, directed_rows[i].raise, directed_rows[i].lower);
    end
    typed_on = 0;

    random_ticks(120);
    drain_results();
    write_beta(1000);
    random_ticks(120);
    drain_results();
    write_beta(10000);
    random_ticks(120);
    drain_results();
    write_beta(0);
    random_ticks(80);
    drain_results();
    write_beta(16383);
    random_ticks(80);
    drain_results();
    write_beta($urandom_range(1000, 10000));
    random_ticks(80);
    drain_results();
    write_beta(3950);

    // Hold one button for a while so the setpoint moves steadily each way.
    gaps_on = 0;
    rx_stall_on = 0;
    for (int i = 0; i < 100; i++) send_tick(12'($urandom_range(1500, 3500)), 1, 0);
    for (int i = 0; i < 100; i++) send_tick(12'($urandom_range(1500, 3500)), 0, 1);
    gaps_on = 1;
    rx_stall_on = 1;
    random_ticks(60);

    drain_results();
    if (errors == 0) $display("thermistor_alarm_monitor_unit_test: PASS");
    else $display("thermistor_alarm_monitor_unit_test: FAIL");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/tam_pkg.sv
rtl/tam_ram.sv
rtl/tam_div.sv
rtl/tam_datapath.sv
rtl/tam_ctrl.sv
rtl/thermistor_alarm_monitor_unit.sv
tb/thermistor_alarm_monitor_unit_test.sv
